// ===== rtl/core/bilp_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte integer literal parser package
// Word types, parser state and status codes shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bilp_pkg;

  // Status codes carried with every result word.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  // Accumulator saturation point and the largest byte value.
  localparam logic [8:0] ACC_SAT  = 9'd256;
  localparam logic [8:0] BYTE_MAX = 9'd255;

  // Parse phase of the current token.
  typedef enum logic [2:0] {
    PH_EMPTY = 3'd0,
    PH_BLANK = 3'd1,
    PH_SIGN  = 3'd2,
    PH_ZERO  = 3'd3,
    PH_XPFX  = 3'd4,
    PH_DEC   = 3'd5,
    PH_OCT   = 3'd6,
    PH_HEX   = 3'd7
  } phase_t;

  // One input word: a character of the token.
  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       last;
  } bilp_in_t;

  // One result word.
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
  } bilp_out_t;

  // Parser state carried from one character to the next.
  typedef struct packed {
    phase_t     phase;
    logic [8:0] accum;
    logic       negative;
    logic       bad_char;
    logic       any_digit;
  } bilp_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bilp_step.sv =====
// ----------------------------------------------------------------------------
// Byte integer literal parser step
// Consumes one character against the current state and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bilp_step (
  input  var bilp_pkg::bilp_state_t st,
  input  var bilp_pkg::bilp_in_t    word,
  output var bilp_pkg::bilp_state_t st_nxt,
  output var bilp_pkg::bilp_out_t   result
);

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  logic        is_blank;
  logic        is_num;
  logic        is_hex_letter;
  logic        is_oct;
  logic [3:0]  dig;
  logic        take;
  logic        bad;
  logic [1:0]  base;
  logic [12:0] acc_ext;
  logic [12:0] prod;
  logic [12:0] sum;
  bilp_pkg::bilp_state_t after;

  // Character classes.
  assign is_blank = (word.ch == 8'h20) || ((word.ch >= 8'h09) && (word.ch <= 8'h0d));
  assign is_num = (word.ch >= 8'h30) && (word.ch <= 8'h39);
  assign is_hex_letter = ((word.ch >= 8'h61) && (word.ch <= 8'h66)) ||
                         ((word.ch >= 8'h41) && (word.ch <= 8'h46));
  assign is_oct = (word.ch >= 8'h30) && (word.ch <= 8'h37);
  assign dig = is_num ? word.ch[3:0] : (word.ch[3:0] + 4'd9);

  // Phase transitions for one character.
  always_comb begin
    after = st;
    take  = 1'b0;
    bad   = 1'b0;
    base  = BASE_DEC;
    if (!word.no_char && !st.bad_char) begin
      unique case (st.phase)
        bilp_pkg::PH_EMPTY, bilp_pkg::PH_BLANK, bilp_pkg::PH_SIGN: begin
          priority if ((st.phase != bilp_pkg::PH_SIGN) && is_blank) begin
            after.phase = bilp_pkg::PH_BLANK;
          end else if ((st.phase != bilp_pkg::PH_SIGN) &&
                       ((word.ch == 8'h2b) || (word.ch == 8'h2d))) begin
            after.negative = (word.ch == 8'h2d);
            after.phase    = bilp_pkg::PH_SIGN;
          end else if (word.ch == 8'h30) begin
            after.phase     = bilp_pkg::PH_ZERO;
            after.any_digit = 1'b1;
            after.accum     = '0;
          end else if (is_num) begin
            after.phase = bilp_pkg::PH_DEC;
            take        = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        bilp_pkg::PH_ZERO: begin
          priority if ((word.ch == 8'h78) || (word.ch == 8'h58)) begin
            after.phase = bilp_pkg::PH_XPFX;
          end else if (is_oct) begin
            after.phase = bilp_pkg::PH_OCT;
            take        = 1'b1;
            base        = BASE_OCT;
          end else begin
            bad = 1'b1;
          end
        end
        bilp_pkg::PH_XPFX, bilp_pkg::PH_HEX: begin
          if (is_num || is_hex_letter) begin
            after.phase = bilp_pkg::PH_HEX;
            take        = 1'b1;
            base        = BASE_HEX;
          end else begin
            bad = 1'b1;
          end
        end
        bilp_pkg::PH_DEC: begin
          if (is_num) begin
            take = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        bilp_pkg::PH_OCT: begin
          if (is_oct) begin
            take = 1'b1;
            base = BASE_OCT;
          end else begin
            bad = 1'b1;
          end
        end
      endcase
    end
    if (bad) begin
      after.bad_char = 1'b1;
    end
    if (take) begin
      after.any_digit = 1'b1;
      after.accum     = (sum > {4'd0, bilp_pkg::ACC_SAT}) ? bilp_pkg::ACC_SAT : sum[8:0];
    end
  end

  // Multiply by the base with shifts, then add the digit.
  assign acc_ext = {4'd0, st.accum};
  always_comb begin
    unique case (base)
      BASE_OCT: prod = acc_ext << 3;
      BASE_HEX: prod = acc_ext << 4;
      default:  prod = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end
  assign sum = prod + {9'd0, dig};

  // Result of the token and the state for the next character.
  always_comb begin
    result.value  = '0;
    result.status = bilp_pkg::STATUS_OK;
    priority if (after.bad_char || (after.phase == bilp_pkg::PH_XPFX) ||
                 ((after.phase != bilp_pkg::PH_EMPTY) && !after.any_digit)) begin
      result.status = bilp_pkg::STATUS_INVALID;
    end else if ((after.accum > bilp_pkg::BYTE_MAX) ||
                 (after.negative && (after.accum != '0))) begin
      result.status = bilp_pkg::STATUS_RANGE;
    end else begin
      result.value = after.accum[7:0];
    end

    st_nxt = after;
    if (word.last) begin
      st_nxt.phase     = bilp_pkg::PH_EMPTY;
      st_nxt.accum     = '0;
      st_nxt.negative  = 1'b0;
      st_nxt.bad_char  = 1'b0;
      st_nxt.any_digit = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bilp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Byte integer literal parser output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bilp_out_reg (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                load,
  input  var bilp_pkg::bilp_out_t load_data,
  output var logic                ready,
  output var logic                out_vld,
  input  var logic                out_stall,
  output var bilp_pkg::bilp_out_t out_data
);

  logic                vld_r;
  logic                vld_nxt;
  bilp_pkg::bilp_out_t data_r;

  // The register is free when empty or when its word leaves this cycle.
  assign ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

// ===== rtl/core/byte_integer_literal_parser_top.sv =====
// ----------------------------------------------------------------------------
// Byte integer literal parser
// Parses a C integer literal, one character per word, into a byte and status.
// ----------------------------------------------------------------------------
// Usage: send the characters of one token on the in_ channel, one per word,
// and mark the final word with last. A word with no_char set carries no
// character; a token made of only such a word is empty and parses as 0, ok.
// Exactly one result word appears on the out_ channel per token, holding
// the value (0 unless ok) and the status: ok, invalid or out of range.
// A word accepted into the input register is parsed there by the parse step,
// and its result is loaded into the output register when the word moves on.
// Throughput is one word per cycle while in_stall is low: the input register
// hands each word to the parse step and the output register holds the result.
// Reset clears both registers and the parse state, ready for a new token.
// When the receiver stalls, the result waits in the output register; words
// that do not end a token keep flowing, and only a last word waits for the
// output register to free, which raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_integer_literal_parser_top (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                in_vld,
  output var logic                in_stall,
  input  var bilp_pkg::bilp_in_t  in_data,
  output var logic                out_vld,
  input  var logic                out_stall,
  output var bilp_pkg::bilp_out_t out_data
);

  logic                  in_vld_r;
  logic                  in_vld_nxt;
  bilp_pkg::bilp_in_t    in_data_r;
  bilp_pkg::bilp_state_t st_r;
  bilp_pkg::bilp_state_t st_nxt;
  bilp_pkg::bilp_out_t   step_result;
  logic                  out_ready;
  logic                  adv;
  logic                  in_take;

  // The held word moves on unless it ends a token and the output is full.
  assign adv      = in_vld_r && (!in_data_r.last || out_ready);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_vld && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_vld_r || adv) begin
      in_vld_nxt = in_vld;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Parse state advances once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= bilp_pkg::PH_EMPTY;
      st_r.accum     <= '0;
      st_r.negative  <= 1'b0;
      st_r.bad_char  <= 1'b0;
      st_r.any_digit <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  bilp_step u_step (
    .st     (st_r),
    .word   (in_data_r),
    .st_nxt (st_nxt),
    .result (step_result)
  );

  bilp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && in_data_r.last),
    .load_data (step_result),
    .ready     (out_ready),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
